### src/dqap_pkg.sv
// ----------------------------------------------------------------------------
// dqap_pkg
// Shared types, character codes and the per-character step function of the
// dotted-quad address parser.
// ----------------------------------------------------------------------------
package dqap_pkg;

  // Parse phase codes.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ZERO  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // Number base codes.
  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // Verdict codes.
  localparam logic [1:0] V_OPEN    = 2'd0;
  localparam logic [1:0] V_VALID   = 2'd1;
  localparam logic [1:0] V_INVALID = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Largest last part for two, three and four parts.
  localparam logic [31:0] LIM_TWO   = 32'h00ff_ffff;
  localparam logic [31:0] LIM_THREE = 32'h0000_ffff;
  localparam logic [31:0] LIM_FOUR  = 32'h0000_00ff;

  localparam logic [1:0] MAX_STORED = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic        address_ok;
    logic [31:0] address_value;
    logic [2:0]  part_count;
  } res_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  base;
    logic [31:0] acc;
    logic [1:0]  nstored;
    logic [1:0]  verdict;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic store;
  } step_t;

  // Applies one character to the parser state. The earlier parts are only
  // read when the last part is closed by a terminator.
  function automatic step_t char_step(st_t s, logic [7:0] c,
                                      logic [31:0] p0, logic [31:0] p1,
                                      logic [31:0] p2);
    step_t       r;
    st_t         d;
    logic        is_dec;
    logic        is_hex_letter;
    logic        is_term;
    logic [31:0] scaled;
    logic [31:0] digit;
    logic [31:0] merged;
    logic        fits;
    r       = '{st: s, store: 1'b0};
    d       = s;
    is_dec  = (c >= CH_0) && (c <= CH_9);
    is_hex_letter = ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    is_term = c inside {CH_NUL, CH_SPACE, [CH_TAB:CH_CR]};
    // Letters a-f and A-F have low bits 1 to 6, so adding nine gives 10 to 15.
    digit   = is_dec ? {28'd0, c[3:0]} : {28'd0, c[3:0] + 4'd9};

    if (s.verdict == V_OPEN) begin
      if (s.phase == PH_START) begin
        if (!is_dec) begin
          r.st.verdict = V_INVALID;
        end else begin
          r.st.acc = {28'd0, c[3:0]};
          if (c == CH_0) begin
            r.st.phase = PH_ZERO;
          end else begin
            r.st.base  = BASE_DEC;
            r.st.phase = PH_DIGIT;
          end
        end
      end else if ((s.phase == PH_ZERO) && ((c == CH_LX) || (c == CH_UX))) begin
        r.st.base  = BASE_HEX;
        r.st.phase = PH_DIGIT;
      end else begin
        if (s.phase == PH_ZERO) begin
          d.base  = BASE_OCT;
          d.phase = PH_DIGIT;
        end
        case (d.base)
          BASE_HEX: scaled = {d.acc[27:0], 4'd0};
          BASE_OCT: scaled = {d.acc[28:0], 3'd0};
          default:  scaled = {d.acc[28:0], 3'd0} + {d.acc[30:0], 1'b0};
        endcase
        case (d.nstored)
          2'd0:    fits = 1'b1;
          2'd1:    fits = d.acc <= LIM_TWO;
          2'd2:    fits = d.acc <= LIM_THREE;
          default: fits = d.acc <= LIM_FOUR;
        endcase
        case (d.nstored)
          2'd0:    merged = d.acc;
          2'd1:    merged = {p0[7:0], 24'd0} | d.acc;
          2'd2:    merged = {p0[7:0], 24'd0} | {p1[15:0], 16'd0} | d.acc;
          default: merged = {p0[7:0], 24'd0} | {p1[15:0], 16'd0}
                            | {p2[23:0], 8'd0} | d.acc;
        endcase
        r.st = d;
        if (is_dec || ((d.base == BASE_HEX) && is_hex_letter)) begin
          r.st.acc = scaled + digit;
        end else if (c == CH_DOT) begin
          if (d.nstored == MAX_STORED) begin
            r.st.verdict = V_INVALID;
          end else begin
            r.store      = 1'b1;
            r.st.nstored = d.nstored + 2'd1;
            r.st.acc     = '0;
            r.st.phase   = PH_START;
          end
        end else if (is_term) begin
          if (fits) begin
            r.st.acc     = merged;
            r.st.verdict = V_VALID;
          end else begin
            r.st.verdict = V_INVALID;
          end
        end else begin
          r.st.verdict = V_INVALID;
        end
      end
    end
    return r;
  endfunction

endpackage

### src/dqap_if.sv
// ----------------------------------------------------------------------------
// dqap_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface dqap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface dqap_out_if;
  logic        valid;
  logic        ready;
  logic        address_ok;
  logic [31:0] address_value;
  logic [2:0]  part_count;

  modport source (output valid, output address_ok, output address_value,
                  output part_count, input ready);
  modport sink   (input valid, input address_ok, input address_value,
                  input part_count, output ready);
endinterface

### src/dqap_in_stage.sv
// ----------------------------------------------------------------------------
// dqap_in_stage
// Input register that holds one character request for the parser.
// ----------------------------------------------------------------------------
module dqap_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dqap_pkg::item_t in_item,
  input  logic           take,
  output logic           stage_valid,
  output dqap_pkg::item_t stage_item
);

  logic            valid_r;
  logic            valid_nxt;
  dqap_pkg::item_t item_r;

  assign in_ready    = !valid_r || take;
  assign valid_nxt   = in_ready ? in_valid : valid_r;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### src/dqap_parser.sv
// ----------------------------------------------------------------------------
// dqap_parser
// Parser state, stored parts and the combinational character step.
// ----------------------------------------------------------------------------
module dqap_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            stage_valid,
  input  dqap_pkg::item_t stage_item,
  input  logic            emit_ok,
  output logic            take,
  output logic            res_valid,
  output dqap_pkg::res_t  res
);

  dqap_pkg::st_t   st_r;
  dqap_pkg::st_t   st_nxt;
  dqap_pkg::st_t   st_reset;
  dqap_pkg::step_t s1;
  dqap_pkg::step_t s2;
  logic [31:0]     parts_r [3];

  assign st_reset = '{phase: dqap_pkg::PH_START, base: dqap_pkg::BASE_DEC,
                      acc: '0, nstored: '0, verdict: dqap_pkg::V_OPEN};

  // The character first, then for the last character an implied NUL.
  assign s1 = dqap_pkg::char_step(st_r, stage_item.char_code,
                                  parts_r[0], parts_r[1], parts_r[2]);
  assign s2 = dqap_pkg::char_step(s1.st, dqap_pkg::CH_NUL,
                                  parts_r[0], parts_r[1], parts_r[2]);

  assign take      = stage_valid && (!stage_item.end_of_string || emit_ok);
  assign res_valid = take && stage_item.end_of_string;

  always_comb begin
    if (s2.st.verdict == dqap_pkg::V_VALID) begin
      res.address_ok    = 1'b1;
      res.address_value = s2.st.acc;
      res.part_count    = {1'b0, s2.st.nstored} + 3'd1;
    end else begin
      res.address_ok    = 1'b0;
      res.address_value = '0;
      res.part_count    = '0;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (take) begin
      st_nxt = stage_item.end_of_string ? st_reset : s1.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_reset;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1.store) begin
      parts_r[st_r.nstored] <= st_r.acc;
    end
  end

endmodule

### src/dqap_out_stage.sv
// ----------------------------------------------------------------------------
// dqap_out_stage
// Result register that holds one parse result until it is taken.
// ----------------------------------------------------------------------------
module dqap_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  dqap_pkg::res_t res,
  output logic           emit_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output dqap_pkg::res_t out_res
);

  logic           valid_r;
  logic           valid_nxt;
  dqap_pkg::res_t res_r;

  assign emit_ok   = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

### src/dotted_quad_address_parser.sv
// ----------------------------------------------------------------------------
// dotted_quad_address_parser
// Parses an IPv4 address string, one character per request, by the classic
// dotted-quad rules: one to four dotted parts, decimal, octal after a leading
// 0, or hex after 0x. A NUL or whitespace closes the address; later characters
// are ignored until the request that carries end_of_string, which alone yields
// a result (address_ok, the 32-bit address with the first part in the top
// byte, and the part count; zeros when the string is invalid). The block takes
// one character every cycle. A character request is caught in the input
// register and then folded into the parser state. On its last character the
// result is written to the output register at the end of the cycle in which
// the parser takes it, so a result passes the input register and the output
// register before it is presented. The only stall is on a last character
// while the output register still holds a result that has not been taken;
// characters before it are never held by the output side.
// ----------------------------------------------------------------------------
module dotted_quad_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  dqap_in_if.sink     in_req,
  dqap_out_if.source  out_res
);

  dqap_pkg::item_t in_item;
  dqap_pkg::item_t stage_item;
  dqap_pkg::res_t  res;
  dqap_pkg::res_t  res_q;
  logic            stage_valid;
  logic            take;
  logic            res_valid;
  logic            emit_ok;

  assign in_item.char_code     = in_req.char_code;
  assign in_item.end_of_string = in_req.end_of_string;

  // Input register: one character request waiting for the parser.
  dqap_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_item     (in_item),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // Parser: consumes the held character, and on the last one also the
  // implied NUL, producing the result in the same cycle.
  dqap_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .emit_ok     (emit_ok),
    .take        (take),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register: holds the result until the consumer takes it.
  dqap_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .emit_ok   (emit_ok),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_res   (res_q)
  );

  assign out_res.address_ok    = res_q.address_ok;
  assign out_res.address_value = res_q.address_value;
  assign out_res.part_count    = res_q.part_count;

  // An invalid verdict always reports a zero address and no parts.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.address_ok)
      |-> (out_res.address_value == 32'd0 && out_res.part_count == 3'd0))
    else $error("invalid result carries nonzero fields");

  // A valid verdict counts between one and four parts.
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.address_ok)
      |-> (out_res.part_count != 3'd0 && out_res.part_count <= 3'd4))
    else $error("valid result with bad part count");

  // A new result only follows a last character taken by the parser.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(res_valid))
    else $error("result appeared without a last character");

  // A last character is never taken while a held result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_res.valid) |-> out_res.ready)
    else $error("held result overwritten");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams address strings into dotted_quad_address_parser one character per
// request and checks every parse result against a predictor in this file.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  dqap_in_if  in_req ();
  dqap_out_if out_res ();

  dotted_quad_address_parser uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  // --------------------------------------------------------------------------
  // Parser predictor. It mirrors the classic dotted-quad rules: a part starts
  // with a digit, a leading 0 switches to octal (8 and 9 still count, weighted
  // by 8), 0x or 0X switches to hex, and a NUL or whitespace closes the address.
  // --------------------------------------------------------------------------
  logic [1:0]  scan_phase;
  logic [1:0]  scan_base;
  logic [1:0]  scan_verdict;
  logic [31:0] scan_value;
  logic [31:0] held_parts [3];
  int          held_count;

  // Expected parse results, oldest first.
  dqap_pkg::res_t pending_results[$];

  int          error_count;
  int          sent_items;
  // When set, neither side inserts idle cycles, so requests run back to back.
  bit          steady_flow;

  function automatic bit is_digit(logic [7:0] c);
    return (c >= dqap_pkg::CH_0) && (c <= dqap_pkg::CH_9);
  endfunction

  function automatic bit is_terminator(logic [7:0] c);
    return (c == dqap_pkg::CH_NUL) || (c == dqap_pkg::CH_SPACE)
           || ((c >= dqap_pkg::CH_TAB) && (c <= dqap_pkg::CH_CR));
  endfunction

  function automatic void restart_scan();
    scan_phase   = dqap_pkg::PH_START;
    scan_base    = dqap_pkg::BASE_DEC;
    scan_value   = '0;
    held_count   = 0;
    scan_verdict = dqap_pkg::V_OPEN;
  endfunction

  // The last part has to fit into the bits the earlier parts leave free.
  // Earlier parts are ORed in without a range check; only their low bits
  // survive the shift.
  function automatic void close_address();
    logic [31:0] limit;
    logic [31:0] merged;
    case (held_count)
      0:       limit = '1;
      1:       limit = dqap_pkg::LIM_TWO;
      2:       limit = dqap_pkg::LIM_THREE;
      default: limit = dqap_pkg::LIM_FOUR;
    endcase
    if (scan_value > limit) begin
      scan_verdict = dqap_pkg::V_INVALID;
    end else begin
      merged = scan_value;
      if (held_count >= 1) merged = merged | (held_parts[0] << 24);
      if (held_count >= 2) merged = merged | (held_parts[1] << 16);
      if (held_count >= 3) merged = merged | (held_parts[2] << 8);
      scan_value   = merged;
      scan_verdict = dqap_pkg::V_VALID;
    end
  endfunction

  function automatic void feed_char(logic [7:0] c);
    logic [31:0] radix;
    logic [31:0] code;
    code = {24'd0, c};
    if (scan_verdict != dqap_pkg::V_OPEN) return;
    if (scan_phase == dqap_pkg::PH_START) begin
      if (!is_digit(c)) begin
        scan_verdict = dqap_pkg::V_INVALID;
        return;
      end
      scan_value = code - {24'd0, dqap_pkg::CH_0};
      if (c == dqap_pkg::CH_0) begin
        scan_phase = dqap_pkg::PH_ZERO;
      end else begin
        scan_base  = dqap_pkg::BASE_DEC;
        scan_phase = dqap_pkg::PH_DIGIT;
      end
      return;
    end
    if (scan_phase == dqap_pkg::PH_ZERO) begin
      if ((c == dqap_pkg::CH_LX) || (c == dqap_pkg::CH_UX)) begin
        scan_base  = dqap_pkg::BASE_HEX;
        scan_phase = dqap_pkg::PH_DIGIT;
        return;
      end
      scan_base  = dqap_pkg::BASE_OCT;
      scan_phase = dqap_pkg::PH_DIGIT;
    end
    radix = (scan_base == dqap_pkg::BASE_HEX) ? 32'd16
            : ((scan_base == dqap_pkg::BASE_OCT) ? 32'd8 : 32'd10);
    if (is_digit(c)) begin
      scan_value = scan_value * radix + (code - {24'd0, dqap_pkg::CH_0});
    end else if ((scan_base == dqap_pkg::BASE_HEX)
                 && (c >= dqap_pkg::CH_LA) && (c <= dqap_pkg::CH_LF)) begin
      scan_value = (scan_value << 4) | (code - {24'd0, dqap_pkg::CH_LA} + 32'd10);
    end else if ((scan_base == dqap_pkg::BASE_HEX)
                 && (c >= dqap_pkg::CH_UA) && (c <= dqap_pkg::CH_UF)) begin
      scan_value = (scan_value << 4) | (code - {24'd0, dqap_pkg::CH_UA} + 32'd10);
    end else if (c == dqap_pkg::CH_DOT) begin
      if (held_count >= 3) begin
        scan_verdict = dqap_pkg::V_INVALID;
      end else begin
        held_parts[held_count] = scan_value;
        held_count++;
        scan_value = '0;
        scan_phase = dqap_pkg::PH_START;
      end
    end else if (is_terminator(c)) begin
      close_address();
    end else begin
      scan_verdict = dqap_pkg::V_INVALID;
    end
  endfunction

  // Applies one accepted request. The end-of-string flag behaves like a NUL
  // after the request's own character and produces the one result.
  function automatic void note_request(logic [7:0] c, logic eos);
    dqap_pkg::res_t want;
    sent_items++;
    feed_char(c);
    if (!eos) return;
    feed_char(dqap_pkg::CH_NUL);
    if (scan_verdict == dqap_pkg::V_VALID) begin
      want.address_ok    = 1'b1;
      want.address_value = scan_value;
      want.part_count    = 3'(held_count + 1);
    end else begin
      want.address_ok    = 1'b0;
      want.address_value = '0;
      want.part_count    = '0;
    end
    pending_results.push_back(want);
    restart_scan();
  endfunction

  // Idle cycles before the next request or the next result. At least a quarter
  // of the draws are zero so that long runs without gaps occur as well.
  function automatic int draw_gap();
    if (steady_flow) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, limit on the run time and the result side.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The slowest correct run is well under a tenth of this.
  initial begin
    #2000000;
    $display("dotted_quad_address_parser test failed");
    $finish;
  end

  // The receiver holds ready low for a random number of cycles before each
  // result and then keeps it high until the result is taken.
  initial begin : result_ready
    int gap;
    out_res.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        out_res.ready <= 1'b0;
        @(negedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk);
      while (out_res.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    dqap_pkg::res_t want;
    if ((out_res.valid === 1'b1) && (out_res.ready === 1'b1)) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: ok %b value %h parts %0d",
               out_res.address_ok, out_res.address_value, out_res.part_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_res.address_ok !== want.address_ok) begin
          $error("address_ok: expected %b, got %b", want.address_ok, out_res.address_ok);
          error_count++;
        end
        if (out_res.address_value !== want.address_value) begin
          $error("address_value: expected %h, got %h",
                 want.address_value, out_res.address_value);
          error_count++;
        end
        if (out_res.part_count !== want.part_count) begin
          $error("part_count: expected %0d, got %0d", want.part_count, out_res.part_count);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Every task starts and ends at a falling edge; valid stays
  // high between requests that follow without a gap.
  // --------------------------------------------------------------------------
  task automatic send_char(logic [7:0] c, logic eos);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.char_code     <= c;
    in_req.end_of_string <= eos;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    note_request(c, eos);
    @(negedge clk);
  endtask

  // Sends a whole string; the last character carries end_of_string.
  task automatic send_string(byte_q_t chars);
    for (int i = 0; i < chars.size(); i++) begin
      send_char(chars[i], i == chars.size() - 1);
    end
  endtask

  // Text, optionally followed by a NUL and further characters after it.
  task automatic send_text(string head, bit with_nul = 1'b0, string after_nul = "");
    byte_q_t chars;
    for (int i = 0; i < head.len(); i++) chars.push_back(head[i]);
    if (with_nul) chars.push_back(dqap_pkg::CH_NUL);
    for (int i = 0; i < after_nul.len(); i++) chars.push_back(after_nul[i]);
    send_string(chars);
  endtask

  // Holds the request side idle until every pending result has come back.
  task automatic drain_results();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random string builder.
  // --------------------------------------------------------------------------
  function automatic void push_text(ref byte_q_t chars, input string s);
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
  endfunction

  // One number in a random base. The last part usually fits its slot; when
  // too_wide is set it is pushed just past it. A free run of digits now and
  // then wraps the 32-bit value or puts 8 and 9 into an octal part.
  function automatic void push_part(ref byte_q_t chars, input logic [31:0] limit,
                                    input bit last_part, input bit too_wide);
    logic [31:0] v;
    string       s;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) begin
        chars.push_back(8'($urandom_range(dqap_pkg::CH_0, dqap_pkg::CH_9)));
      end
      return;
    end
    if (pick < 11) begin
      push_text(chars, ($urandom_range(0, 1) == 1) ? "0x" : "0X");
      return;
    end
    if (!last_part) begin
      v = ($urandom_range(0, 5) == 0) ? 32'($urandom) : 32'($urandom_range(0, 255));
    end else if (too_wide && (limit != '1)) begin
      v = limit + 32'($urandom_range(1, 300));
    end else if ($urandom_range(0, 1) == 0) begin
      v = (limit < 32'd255) ? limit : 32'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) v = limit;
    end else begin
      v = 32'($urandom) & limit;
    end
    case ($urandom_range(0, 2))
      0: s = $sformatf("%0d", v);
      1: s = $sformatf("0%0o", v);
      default: begin
        s = $sformatf("0%s%0h", ($urandom_range(0, 1) == 1) ? "x" : "X", v);
        for (int i = 2; i < s.len(); i++) begin
          if ((s[i] >= dqap_pkg::CH_LA) && (s[i] <= dqap_pkg::CH_LF)
              && ($urandom_range(0, 1) == 1)) begin
            s[i] = s[i] - (dqap_pkg::CH_LA - dqap_pkg::CH_UA);
          end
        end
      end
    endcase
    push_text(chars, s);
  endfunction

  function automatic logic [7:0] pick_terminator();
    int k;
    k = $urandom_range(0, 6);
    if (k == 0) return dqap_pkg::CH_NUL;
    if (k == 1) return dqap_pkg::CH_SPACE;
    return dqap_pkg::CH_TAB + 8'(k - 2);
  endfunction

  // Mostly well-formed addresses with random content; some carry one defect
  // and a few are plain noise bytes.
  function automatic byte_q_t make_address();
    byte_q_t     chars;
    int          nparts;
    int          kind;
    int          defect;
    logic [31:0] limit;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
      return chars;
    end
    defect = (kind >= 70) ? $urandom_range(0, 4) : -1;
    nparts = $urandom_range(1, 4);
    case (nparts)
      1:       limit = '1;
      2:       limit = dqap_pkg::LIM_TWO;
      3:       limit = dqap_pkg::LIM_THREE;
      default: limit = dqap_pkg::LIM_FOUR;
    endcase
    for (int p = 0; p < nparts; p++) begin
      if (p > 0) chars.push_back(dqap_pkg::CH_DOT);
      push_part(chars, limit, p == nparts - 1, defect == 3);
    end
    case (defect)
      0: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      1: chars.insert($urandom_range(0, chars.size()), dqap_pkg::CH_DOT);
      2: begin
        if (nparts < 4) begin
          repeat (4 - nparts) push_text(chars, ".1");
        end
        push_text(chars, ".7");
      end
      4: if (chars.size() > 1) chars.delete($urandom_range(0, chars.size() - 1));
      default: ;
    endcase
    case ($urandom_range(0, 2))
      1: chars.push_back(pick_terminator());
      2: begin
        chars.push_back(pick_terminator());
        repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    return chars;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Plain addresses with one to four parts, up to the widest last parts.
  task automatic test_well_formed_addresses();
    send_text("1.2.3.4");
    send_text("4294967295", 1'b1);
    send_text("1.16777215");
    send_text("10.0.65535 ");
    send_text("255.255.255.255");
  endtask

  // Octal with digits 8 and 9, hex in both cases, and a bare 0x prefix.
  task automatic test_number_bases();
    send_text("0xFF.0377.0Xa.9");
    send_text("0x");
    send_text("0189");
    send_text("0xAbCdEf01");
  endtask

  // Empty string, misplaced dots, a fifth part, stray characters and a last
  // part one past its slot.
  task automatic test_malformed_addresses();
    send_text("", 1'b1);
    send_text(".1");
    send_text("1..2");
    send_text("1.");
    send_text("1.2.3.4.5");
    send_text("1.2.3.256");
    send_text("1.2.65536");
    send_text("12a");
    send_text("1\xff");
    send_text("0xg");
  endtask

  // Each whitespace terminator, and characters after the verdict that must
  // be ignored until end of string.
  task automatic test_terminators_and_tail();
    send_text("9\tzz");
    send_text("7\r.");
    send_text("8\n\v");
    send_text("6\f");
    send_text("5 5");
    send_text("3", 1'b1, "x.\xff");
  endtask

  // Random strings until the whole run has sent item_goal requests. Halfway
  // through the sender waits for the result side to drain completely before
  // it goes on.
  task automatic test_random_strings(int item_goal);
    bit drained;
    drained = 1'b0;
    while (sent_items < item_goal) begin
      steady_flow = ($urandom_range(0, 7) == 0);
      send_string(make_address());
      if (!drained && (sent_items >= item_goal / 2)) begin
        drain_results();
        drained = 1'b1;
      end
    end
    steady_flow = 1'b0;
  endtask

  // Requests and results back to back on both sides.
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (6) send_string(make_address());
    steady_flow = 1'b0;
  endtask

  initial begin
    in_req.valid         = 1'b0;
    in_req.char_code     = '0;
    in_req.end_of_string = 1'b0;
    rst_n                = 1'b0;
    error_count          = 0;
    sent_items           = 0;
    steady_flow          = 1'b0;
    for (int i = 0; i < 3; i++) held_parts[i] = '0;
    restart_scan();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_well_formed_addresses();
    test_number_bases();
    test_malformed_addresses();
    test_terminators_and_tail();
    test_back_to_back();
    test_random_strings(550);

    // Wait for the last results, then leave time for anything stray.
    drain_results();
    repeat (8) @(negedge clk);

    if (error_count == 0) begin
      $display("dotted_quad_address_parser test passed");
    end else begin
      $display("dotted_quad_address_parser test failed");
    end
    $finish;
  end

endmodule
